### hw/rtl/simfp_pkg.sv
package simfp_pkg;

  // fixed field widths
  localparam int DATA_W   = 64;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 7;
  localparam int LIMIT_W  = 7;
  localparam int OPC_W    = 2;

  // defaults for the top level parameters
  localparam int FP_BITS_DEF  = 64;
  localparam int SUM_BITS_DEF = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

  // popcount split: groups of GROUP_W bits over the full word
  localparam int GROUP_W = 8;
  localparam int NGROUPS = DATA_W / GROUP_W;
  localparam int CNT_W   = $clog2(GROUP_W + 1);

  typedef enum logic [OPC_W-1:0] {
    OP_ADD     = 2'd0,
    OP_FINISH  = 2'd1,
    OP_COMPARE = 2'd2
  } opcode_t;

  localparam logic KIND_FP   = 1'b0;
  localparam logic KIND_DIST = 1'b1;

  // request handed from the lanes to the merge stage
  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] fingerprint;
    logic [DATA_W-1:0] diff;
  } req_t;

  function automatic logic [CNT_W-1:0] popcount_group(input logic [GROUP_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

### hw/rtl/simfp_lane.sv
module simfp_lane #(
  parameter int SUM_BITS = simfp_pkg::SUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          add_en,
  input  logic                          clr_en,
  input  logic                          hash_bit,
  input  logic [simfp_pkg::WEIGHT_W-1:0] weight,
  output logic                          sum_pos
);

  // working width holds the sum and the weight without overflow
  localparam int BASE_W = (SUM_BITS > simfp_pkg::WEIGHT_W + 1) ? SUM_BITS
                                                               : simfp_pkg::WEIGHT_W + 1;
  localparam int EXT_W  = BASE_W + 1;

  localparam logic signed [EXT_W-1:0] SAT_MAX =
    {{(EXT_W-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SAT_MIN =
    {{(EXT_W-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};

  logic signed [SUM_BITS-1:0] sum_r;
  logic signed [SUM_BITS-1:0] sum_nxt;
  logic signed [EXT_W-1:0]    sum_ext;
  logic signed [EXT_W-1:0]    w_ext;
  logic signed [EXT_W-1:0]    raw;

  // signed add or subtract, then clamp to the sum bounds
  always_comb begin
    sum_ext = EXT_W'(sum_r);
    w_ext   = $signed({{(EXT_W-simfp_pkg::WEIGHT_W){1'b0}}, weight});
    raw     = hash_bit ? (sum_ext + w_ext) : (sum_ext - w_ext);
    if (raw > SAT_MAX) begin
      sum_nxt = SAT_MAX[SUM_BITS-1:0];
    end else if (raw < SAT_MIN) begin
      sum_nxt = SAT_MIN[SUM_BITS-1:0];
    end else begin
      sum_nxt = raw[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (clr_en) begin
      sum_r <= '0;
    end else if (add_en) begin
      sum_r <= sum_nxt;
    end
  end

  // fingerprint bit: strictly positive sum
  assign sum_pos = !sum_r[SUM_BITS-1] && (sum_r != '0);

endmodule

### hw/rtl/simfp_merge.sv
module simfp_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_valid,
  input  simfp_pkg::req_t                 req,
  output logic                            req_ready,
  input  logic [simfp_pkg::LIMIT_W-1:0]   limit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [simfp_pkg::DATA_W-1:0]    out_fp,
  output logic [simfp_pkg::DIST_W-1:0]    out_dist,
  output logic                            out_within
);

  logic                            s1_valid_r;
  logic                            s1_kind_r;
  logic [simfp_pkg::DATA_W-1:0]    s1_fp_r;
  logic [simfp_pkg::CNT_W-1:0]     s1_cnt_r [simfp_pkg::NGROUPS];

  logic                            out_valid_r;
  logic                            out_kind_r;
  logic [simfp_pkg::DATA_W-1:0]    out_fp_r;
  logic [simfp_pkg::DIST_W-1:0]    out_dist_r;
  logic                            out_within_r;

  logic                            adv;
  logic [simfp_pkg::DIST_W-1:0]    dist_sum;

  // pipeline moves when the output register is free or being taken
  assign adv       = !out_valid_r || out_ready;
  assign req_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_valid_r <= req_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // stage 1: per-group popcounts of the difference word
  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_kind_r <= req.kind;
      s1_fp_r   <= req.fingerprint;
      for (int g = 0; g < simfp_pkg::NGROUPS; g++) begin
        s1_cnt_r[g] <= simfp_pkg::popcount_group(
                         req.diff[g*simfp_pkg::GROUP_W +: simfp_pkg::GROUP_W]);
      end
    end
  end

  // stage 2: add the group counts
  always_comb begin
    dist_sum = '0;
    for (int g = 0; g < simfp_pkg::NGROUPS; g++) begin
      dist_sum = dist_sum + simfp_pkg::DIST_W'(s1_cnt_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_kind_r   <= s1_kind_r;
      out_fp_r     <= s1_fp_r;
      // finish results carry zero distance and no near-match flag
      out_dist_r   <= (s1_kind_r == simfp_pkg::KIND_DIST) ? dist_sum : '0;
      out_within_r <= (s1_kind_r == simfp_pkg::KIND_DIST) && (dist_sum <= limit);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_fp     = out_fp_r;
  assign out_dist   = out_dist_r;
  assign out_within = out_within_r;

  // a waiting stage-1 request is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("merge stage 1 request lost under stall");

  // distance never exceeds the word width
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_dist_r <= simfp_pkg::DIST_W'(simfp_pkg::DATA_W))
    else $error("distance out of range");

endmodule

### hw/rtl/simhash_fingerprint_hamming.sv
// channel | dir | tvalid/tready            | tdata / tuser
// --------+-----+--------------------------+------------------------------------------
// in      | in  | in_tvalid / in_tready    | data: word_hash, weight, article_fp; user: opcode
// out     | out | out_tvalid / out_tready  | data: fingerprint, distance, within; user: kind
// cfg     | in  | cfg_valid / cfg_ready    | data: report_limit
//
// One request per cycle while in_tready is high. Add requests update all lane sums at the accepting edge.
// Finish and compare results pass through a popcount stage and the output register;
// the lane sums and stored fingerprint are read directly.
// Reset clears all sums, the stored fingerprint and sets report_limit to 3.
// A stalled output holds the merge pipeline; in_tready drops only when both of
// its stages are full and out_tready is low.
module simhash_fingerprint_hamming #(
  parameter int FINGERPRINT_BITS = simfp_pkg::FP_BITS_DEF,
  parameter int SUM_BITS         = simfp_pkg::SUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [143:0]                  in_tdata,  // word_hash[63:0], weight[79:64],
                                                   // article_fingerprint[143:80]
  input  logic [simfp_pkg::OPC_W-1:0]   in_tuser,  // opcode[1:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [71:0]                   out_tdata, // fingerprint[63:0], distance[70:64],
                                                   // within_limit[71]
  output logic                          out_tuser, // result_kind[0]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [simfp_pkg::LIMIT_W-1:0] cfg_data   // report_limit[6:0]
);

  localparam logic [simfp_pkg::DATA_W-1:0] FP_MASK =
    {simfp_pkg::DATA_W{1'b1}} >> (simfp_pkg::DATA_W - FINGERPRINT_BITS);

  logic [simfp_pkg::DATA_W-1:0]   word_hash;
  logic [simfp_pkg::WEIGHT_W-1:0] weight;
  logic [simfp_pkg::DATA_W-1:0]   article_fp;
  simfp_pkg::opcode_t             opcode;

  logic                           accept;
  logic                           do_add;
  logic                           do_finish;
  logic                           do_compare;

  logic [FINGERPRINT_BITS-1:0]    lane_pos;
  logic [simfp_pkg::DATA_W-1:0]   fp_now;

  logic [simfp_pkg::DATA_W-1:0]   sample_r;
  logic [simfp_pkg::LIMIT_W-1:0]  limit_r;

  simfp_pkg::req_t                req;
  logic                           req_valid;
  logic                           req_ready;

  logic                           m_kind;
  logic [simfp_pkg::DATA_W-1:0]   m_fp;
  logic [simfp_pkg::DIST_W-1:0]   m_dist;
  logic                           m_within;

  // unpack the request
  assign word_hash  = in_tdata[63:0];
  assign weight     = in_tdata[79:64];
  assign article_fp = in_tdata[143:80];
  assign opcode     = simfp_pkg::opcode_t'(in_tuser);

  assign accept = in_tvalid && in_tready;

  // opcode decode; the unused code does nothing
  always_comb begin
    do_add     = 1'b0;
    do_finish  = 1'b0;
    do_compare = 1'b0;
    unique case (opcode)
      simfp_pkg::OP_ADD:     do_add     = 1'b1;
      simfp_pkg::OP_FINISH:  do_finish  = 1'b1;
      simfp_pkg::OP_COMPARE: do_compare = 1'b1;
      default: ;
    endcase
  end

  // one lane per fingerprint bit
  for (genvar j = 0; j < FINGERPRINT_BITS; j++) begin : g_lane
    simfp_lane #(
      .SUM_BITS (SUM_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .add_en   (accept && do_add),
      .clr_en   (accept && do_finish),
      .hash_bit (word_hash[j]),
      .weight   (weight),
      .sum_pos  (lane_pos[j])
    );
  end

  assign fp_now = simfp_pkg::DATA_W'(lane_pos);

  // stored fingerprint and report limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      limit_r  <= simfp_pkg::LIMIT_RESET;
    end else begin
      if (accept && do_finish) begin
        sample_r <= fp_now;
      end
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  assign cfg_ready = 1'b1;

  // request towards the merge stage
  always_comb begin
    req.kind        = do_compare ? simfp_pkg::KIND_DIST : simfp_pkg::KIND_FP;
    req.fingerprint = do_compare ? sample_r : fp_now;
    req.diff        = do_compare ? ((article_fp ^ sample_r) & FP_MASK) : '0;
  end

  assign req_valid = in_tvalid && (do_finish || do_compare);
  assign in_tready = req_ready;

  simfp_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req        (req),
    .req_ready  (req_ready),
    .limit      (limit_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (m_kind),
    .out_fp     (m_fp),
    .out_dist   (m_dist),
    .out_within (m_within)
  );

  assign out_tuser = m_kind;
  assign out_tdata = {m_within, m_dist, m_fp};

  // a finish leaves no positive sum behind
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && do_finish |=> lane_pos == '0)
    else $error("sums not cleared after finish");

  // only a finish changes the stored fingerprint
  a_sample: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && do_finish) |=> $stable(sample_r))
    else $error("stored fingerprint changed without finish");

  // fingerprint results carry no distance and no flag
  a_fp_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == simfp_pkg::KIND_FP |-> out_tdata[71:64] == '0)
    else $error("fingerprint result with distance fields set");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int FP_BITS = simfp_pkg::FP_BITS_DEF;
  localparam int SUM_W   = simfp_pkg::SUM_BITS_DEF;
  localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam logic [63:0] FP_MASK = {64{1'b1}} >> (64 - FP_BITS);
  // opcode outside the enum: the block must ignore it
  localparam logic [simfp_pkg::OPC_W-1:0] OP_RESERVED = 2'd3;
  // results pass through the popcount stage and the output register, so this covers a trailing add
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [simfp_pkg::OPC_W-1:0]    opc;
    logic [63:0]                    hash;
    logic [simfp_pkg::WEIGHT_W-1:0] weight;
    logic [63:0]                    article;
    bit                  near;  // article holds a flip mask against the stored fingerprint
    bit                  hold;  // wait until every result is back before sending
  } request_t;

  typedef struct {
    logic                         kind;
    logic [63:0]                  fingerprint;
    logic [simfp_pkg::DIST_W-1:0] distance;
    logic                         near_ok;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic [simfp_pkg::OPC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [simfp_pkg::LIMIT_W-1:0] cfg_data = '0;

  // predictor state
  longint                        lane_sum [FP_BITS];
  logic [63:0]                   stored_fp;
  logic [simfp_pkg::LIMIT_W-1:0] near_limit;

  request_t request_q [$];
  result_t  results_due [$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;

  simhash_fingerprint_hamming dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // fold one accepted request into the sums and queue the result it causes
  task automatic simhash_predict(input logic [simfp_pkg::OPC_W-1:0] opc,
                                 input logic [63:0] hash,
                                 input logic [simfp_pkg::WEIGHT_W-1:0] weight,
                                 input logic [63:0] article);
    longint  s;
    result_t r;
    logic [63:0] fp;
    logic [63:0] diff;
    int      ones;
    case (opc)
      simfp_pkg::OP_ADD: begin
        for (int j = 0; j < FP_BITS; j++) begin
          s = hash[j] ? lane_sum[j] + longint'(weight) : lane_sum[j] - longint'(weight);
          if (s > SUM_HI) s = SUM_HI;
          if (s < SUM_LO) s = SUM_LO;
          lane_sum[j] = s;
        end
      end
      simfp_pkg::OP_FINISH: begin
        fp = '0;
        for (int j = 0; j < FP_BITS; j++) begin
          fp[j] = (lane_sum[j] > 0);
          lane_sum[j] = 0;
        end
        stored_fp = fp;
        r.kind = simfp_pkg::KIND_FP;
        r.fingerprint = fp;
        r.distance = '0;
        r.near_ok = 1'b0;
        results_due.push_back(r);
      end
      simfp_pkg::OP_COMPARE: begin
        diff = (article ^ stored_fp) & FP_MASK;
        ones = 0;
        for (int j = 0; j < 64; j++) ones += diff[j];
        r.kind = simfp_pkg::KIND_DIST;
        r.fingerprint = stored_fp;
        r.distance = simfp_pkg::DIST_W'(ones);
        r.near_ok = (ones <= near_limit);
        results_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  // driver: presents queued requests, predicting each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        simhash_predict(in_tuser, in_tdata[63:0], in_tdata[79:64], in_tdata[143:80]);
      if (!in_tvalid || in_tready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(request_q[0].hold && results_due.size() != 0)) begin
          request_t q;
          q = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= q.opc;
          in_tdata  <= {q.near ? (stored_fp ^ q.article) : q.article, q.weight, q.hash};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and in-order result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0b fp %h dist %0d within %0b",
                     out_tuser, out_tdata[63:0], out_tdata[70:64], out_tdata[71]);
        end else begin
          result_t e;
          e = results_due.pop_front();
          if (out_tuser !== e.kind || out_tdata[63:0] !== e.fingerprint ||
              out_tdata[70:64] !== e.distance || out_tdata[71] !== e.near_ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0b %h %0d %0b, got %0b %h %0d %0b",
                       e.kind, e.fingerprint, e.distance, e.near_ok,
                       out_tuser, out_tdata[63:0], out_tdata[70:64], out_tdata[71]);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void push_request(input logic [simfp_pkg::OPC_W-1:0] opc,
                                       input logic [63:0] hash,
                                       input logic [simfp_pkg::WEIGHT_W-1:0] weight,
                                       input logic [63:0] article, input bit near,
                                       input bit hold);
    request_t q;
    q.opc = opc;
    q.hash = hash;
    q.weight = weight;
    q.article = article;
    q.near = near;
    q.hold = hold;
    request_q.push_back(q);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [simfp_pkg::WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return simfp_pkg::WEIGHT_W'($urandom_range(15));
      default: return simfp_pkg::WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] flip_mask(input int k);
    logic [63:0] m;
    m = '0;
    repeat (k) m[$urandom_range(63)] = 1'b1;
    return m;
  endfunction

  // mostly add runs closed by a finish and followed by compares, some noise
  task automatic random_traffic(input int n);
    int sent;
    int k;
    logic [simfp_pkg::OPC_W-1:0] opc;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        repeat ($urandom_range(10)) begin
          push_request(simfp_pkg::OP_ADD, rand64(), rand_weight(), rand64(), 0,
                       $urandom_range(49) == 0);
          sent++;
        end
        push_request(simfp_pkg::OP_FINISH, rand64(), rand_weight(), rand64(), 0,
                     $urandom_range(49) == 0);
        sent++;
        repeat ($urandom_range(1, 4)) begin
          k = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(8);
          push_request(simfp_pkg::OP_COMPARE, rand64(), rand_weight(),
                       ($urandom_range(15) == 0) ? '1 : flip_mask(k), 1,
                       $urandom_range(49) == 0);
          sent++;
        end
      end else begin
        opc = simfp_pkg::OPC_W'($urandom_range(3));
        push_request(opc, rand64(), rand_weight(), rand64(), 0, 0);
        if (opc != OP_RESERVED) sent++;
      end
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_tvalid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [simfp_pkg::LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    near_limit = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [simfp_pkg::LIMIT_W-1:0] limit, input int idle,
                           input int stall, input int n);
    write_limit(limit);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    push_request(simfp_pkg::OP_FINISH, '0, '0, '0, 0, 0);
    random_traffic(n);
    // pause until everything is back, then carry on in the same phase
    push_request(simfp_pkg::OP_COMPARE, '0, '0, flip_mask(2), 1, 1);
    wait_drained();
  endtask

  // sequencing: reset, directed cases, large sums, then random phases
  initial begin
    logic [63:0] pat;
    for (int j = 0; j < FP_BITS; j++) lane_sum[j] = 0;
    stored_fp  = '0;
    near_limit = simfp_pkg::LIMIT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // stored fingerprint is zero after reset
    push_request(simfp_pkg::OP_COMPARE, '0, '0, '0, 0, 0);
    push_request(simfp_pkg::OP_COMPARE, '1, '1, '1, 0, 0);
    // finish with empty sums gives zero
    push_request(simfp_pkg::OP_FINISH, '0, '0, '0, 0, 0);
    // full-weight add with all hash bits set, zero-weight add does nothing
    push_request(simfp_pkg::OP_ADD, '1, '1, '0, 0, 0);
    push_request(simfp_pkg::OP_ADD, '0, '0, '1, 0, 0);
    push_request(simfp_pkg::OP_FINISH, '0, '0, '0, 0, 0);
    // distances at, just over and far from the default limit
    push_request(simfp_pkg::OP_COMPARE, '0, '0, flip_mask(0), 1, 0);
    push_request(simfp_pkg::OP_COMPARE, '0, '0, 64'h8000_0000_0000_0401, 1, 0);
    push_request(simfp_pkg::OP_COMPARE, '0, '0, 64'h8000_0000_0000_0403, 1, 0);
    push_request(simfp_pkg::OP_COMPARE, '0, '0, '1, 1, 0);
    // reserved opcode with busy fields leaves state alone
    push_request(OP_RESERVED, '1, '1, '1, 0, 0);
    push_request(simfp_pkg::OP_COMPARE, '0, '0, 64'h0000_0000_0000_00ff, 0, 0);
    // equal and opposite adds cancel to zero, which is not positive
    pat = 64'hf0f0_3c3c_a5a5_0ff0;
    push_request(simfp_pkg::OP_ADD, pat, 16'd10, '0, 0, 0);
    push_request(simfp_pkg::OP_ADD, ~pat, 16'd10, '0, 0, 0);
    push_request(simfp_pkg::OP_FINISH, '0, '0, '0, 0, 0);
    // single unit of weight
    push_request(simfp_pkg::OP_ADD, pat, 16'd1, '0, 0, 0);
    push_request(simfp_pkg::OP_FINISH, '0, '0, '0, 0, 0);
    push_request(simfp_pkg::OP_COMPARE, '0, '0, pat, 0, 0);

    // large sums: opposing full-weight runs, then one odd weight leaves +/- 32767
    pat = 64'h5555_5555_5555_5555;
    repeat (24) push_request(simfp_pkg::OP_ADD, pat, '1, '0, 0, 0);
    repeat (24) push_request(simfp_pkg::OP_ADD, ~pat, '1, '0, 0, 0);
    push_request(simfp_pkg::OP_ADD, ~pat, 16'd32767, '0, 0, 0);
    push_request(simfp_pkg::OP_FINISH, '0, '0, '0, 0, 0);
    push_request(simfp_pkg::OP_COMPARE, '0, '0, '0, 0, 0);
    wait_drained();

    run_phase(7'd0,  0,  0,  150);
    run_phase(7'd64, 81, 0,  150);
    run_phase(7'd127, 0, 81, 150);
    run_phase(simfp_pkg::LIMIT_W'($urandom_range(127)), 16, 16, 150);
    run_phase(simfp_pkg::LIMIT_W'($urandom_range(8)), 0, 0, 150);

    if (results_due.size() != 0) mismatches += results_due.size();
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
